[sv/sia_pkg.sv]
// Package for the instance slot allocator with aging.
// Holds status codes, outcome codes, defaults and the slot evaluation struct.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sia_pkg;

  localparam int DEF_NUM_SLOTS = 128;
  localparam int DEF_KEY_BITS  = 32;

  localparam logic [6:0] ST_FREE         = 7'd0;
  localparam logic [6:0] ST_ACTIVE       = 7'd1;
  localparam logic [6:0] ST_INACT_START  = 7'd2;
  localparam logic [6:0] SCORE_MAX       = 7'd127;
  localparam logic [6:0] THR_RESET       = 7'd64;
  localparam logic [7:0] EXP_MAX         = 8'd255;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    OUT_OK         = 2'd0,
    OUT_FULL       = 2'd1,
    OUT_NOT_ACTIVE = 2'd2
  } outcome_t;

  typedef struct packed {
    logic       is_free;
    logic       is_active;
    logic       is_inactive;
    logic       key_match;
    logic       expire;
    logic [6:0] aged;
  } slot_eval_t;

  typedef struct packed {
    logic st_we;
    logic ow_we;
  } tbl_we_t;

endpackage

`default_nettype wire

[sv/sia_table.sv]
// Slot table memories: per-slot status and owner key, one read and one write port each.
// Read data is registered. Depends on sia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sia_table #(
  parameter int NUM_SLOTS = sia_pkg::DEF_NUM_SLOTS,
  parameter int KEY_BITS  = sia_pkg::DEF_KEY_BITS,
  localparam int IDX_W    = $clog2(NUM_SLOTS)
) (
  input  wire                  clk,
  input  wire  [IDX_W-1:0]     rd_addr,
  output logic [6:0]           rd_status,
  output logic [KEY_BITS-1:0]  rd_owner,
  input  sia_pkg::tbl_we_t     we,
  input  wire  [IDX_W-1:0]     wr_addr,
  input  wire  [6:0]           st_wdata,
  input  wire  [KEY_BITS-1:0]  ow_wdata
);

  logic [6:0]          status_mem [NUM_SLOTS];
  logic [KEY_BITS-1:0] owner_mem  [NUM_SLOTS];
  logic [6:0]          rd_status_r;
  logic [KEY_BITS-1:0] rd_owner_r;

  always_ff @(posedge clk) begin
    if (we.st_we) begin
      status_mem[wr_addr] <= st_wdata;
    end
    rd_status_r <= status_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.ow_we) begin
      owner_mem[wr_addr] <= ow_wdata;
    end
    rd_owner_r <= owner_mem[rd_addr];
  end

  assign rd_status = rd_status_r;
  assign rd_owner  = rd_owner_r;

endmodule

`default_nettype wire

[sv/sia_slot_unit.sv]
// Shared slot evaluation unit: classifies one slot, compares its key and ages its score.
// Depends on sia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sia_slot_unit #(
  parameter int KEY_BITS = sia_pkg::DEF_KEY_BITS
) (
  input  wire  [6:0]          status,
  input  wire  [KEY_BITS-1:0] owner,
  input  wire  [KEY_BITS-1:0] key,
  input  wire  [6:0]          thr,
  output sia_pkg::slot_eval_t ev
);

  logic [6:0] aged;

  always_comb begin
    aged = (status < sia_pkg::SCORE_MAX) ? status + 7'd1 : status;
    ev.is_free     = (status == sia_pkg::ST_FREE);
    ev.is_active   = (status == sia_pkg::ST_ACTIVE);
    ev.is_inactive = (status >= sia_pkg::ST_INACT_START);
    ev.key_match   = (owner == key);
    ev.expire      = (aged >= thr);
    ev.aged        = aged;
  end

endmodule

`default_nettype wire

[sv/sia_seq.sv]
// Sequencer of the slot allocator: clears the table, scans it one slot a cycle and
// writes back. Holds the threshold register and the result registers. Depends on sia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sia_seq #(
  parameter int NUM_SLOTS = sia_pkg::DEF_NUM_SLOTS,
  parameter int KEY_BITS  = sia_pkg::DEF_KEY_BITS,
  localparam int IDX_W    = $clog2(NUM_SLOTS)
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire                  in_kind,
  input  wire  [31:0]          in_owner_key,
  input  wire  [6:0]           in_slot_index,
  input  wire                  cfg_wr_en,
  input  wire  [6:0]           cfg_wr_data,
  output logic [IDX_W-1:0]     rd_addr,
  input  wire  [KEY_BITS-1:0]  rd_owner,
  input  sia_pkg::slot_eval_t  ev,
  output logic [KEY_BITS-1:0]  key,
  output logic [6:0]           thr,
  output sia_pkg::tbl_we_t     we,
  output logic [IDX_W-1:0]     wr_addr,
  output logic [6:0]           st_wdata,
  output logic [KEY_BITS-1:0]  ow_wdata,
  output logic                 out_valid,
  output logic [1:0]           out_outcome,
  output logic [6:0]           out_granted_slot,
  output logic                 out_reused,
  output logic                 out_kept_inactive,
  output logic [7:0]           out_expired_count
);

  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int CMP_W = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_REL_RD, S_REL_CHK, S_SCAN, S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    addr_r, addr_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pend_addr_r, pend_addr_nxt;
  logic                kind_r, kind_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [6:0]          idx7_r, idx7_nxt;
  logic                oor_r, oor_nxt;
  logic                fi_r, fi_nxt;
  logic [IDX_W-1:0]    islot_r, islot_nxt;
  logic                ff_r, ff_nxt;
  logic [IDX_W-1:0]    fslot_r, fslot_nxt;
  logic                last_r, last_nxt;
  logic [7:0]          exp_r, exp_nxt;
  logic [6:0]          thr_r, thr_nxt;
  logic                ov_r, ov_nxt;
  sia_pkg::outcome_t   outcome_r, outcome_nxt;
  logic [6:0]          granted_r, granted_nxt;
  logic                reused_r, reused_nxt;
  logic                kept_r, kept_nxt;
  logic [7:0]          expired_r, expired_nxt;

  logic [IDX_W-1:0]    in_idx;
  logic [IDX_W-1:0]    g_slot;
  logic [CMP_W-1:0]    g_wide;

  assign in_idx = IDX_W'(in_slot_index);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = pend_addr_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    idx7_nxt      = idx7_r;
    oor_nxt       = oor_r;
    fi_nxt        = fi_r;
    islot_nxt     = islot_r;
    ff_nxt        = ff_r;
    fslot_nxt     = fslot_r;
    last_nxt      = last_r;
    exp_nxt       = exp_r;
    thr_nxt       = cfg_wr_en ? cfg_wr_data : thr_r;
    ov_nxt        = 1'b0;
    outcome_nxt   = outcome_r;
    granted_nxt   = granted_r;
    reused_nxt    = reused_r;
    kept_nxt      = kept_r;
    expired_nxt   = expired_r;
    we            = '0;
    wr_addr       = pend_addr_r;
    st_wdata      = sia_pkg::ST_FREE;
    ow_wdata      = key_r;
    g_slot        = fi_r ? islot_r : fslot_r;
    g_wide        = CMP_W'(g_slot);

    unique case (state_r)
      S_CLEAR: begin
        we.st_we = 1'b1;
        wr_addr  = addr_r[IDX_W-1:0];
        addr_nxt = addr_r + CNT_W'(1);
        if (addr_r[IDX_W-1:0] == IDX_W'(NUM_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          kind_nxt = in_kind;
          key_nxt  = KEY_BITS'(in_owner_key);
          idx_nxt  = in_idx;
          idx7_nxt = in_slot_index;
          oor_nxt  = (CMP_W'(in_slot_index) >= CMP_W'(NUM_SLOTS));
          fi_nxt   = 1'b0;
          ff_nxt   = 1'b0;
          last_nxt = 1'b1;
          exp_nxt  = 8'd0;
          if (in_kind == sia_pkg::KIND_RELEASE) begin
            addr_nxt  = CNT_W'(in_idx);
            state_nxt = S_REL_RD;
          end else begin
            addr_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_REL_RD: begin
        state_nxt = S_REL_CHK;
      end
      S_REL_CHK: begin
        if (oor_r || !ev.is_active) begin
          ov_nxt      = 1'b1;
          outcome_nxt = sia_pkg::OUT_NOT_ACTIVE;
          granted_nxt = idx7_r;
          reused_nxt  = 1'b0;
          kept_nxt    = 1'b0;
          expired_nxt = 8'd0;
          state_nxt   = S_IDLE;
        end else begin
          key_nxt   = rd_owner;
          addr_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (addr_r != CNT_W'(NUM_SLOTS)) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = addr_r[IDX_W-1:0];
          addr_nxt      = addr_r + CNT_W'(1);
        end else begin
          state_nxt = S_FIN;
        end
        if (pend_r) begin
          if (kind_r == sia_pkg::KIND_ALLOC) begin
            if (ev.is_inactive && ev.key_match && !fi_r) begin
              fi_nxt    = 1'b1;
              islot_nxt = pend_addr_r;
            end
            if (ev.is_free && !ff_r) begin
              ff_nxt    = 1'b1;
              fslot_nxt = pend_addr_r;
            end
          end else begin
            if (ev.is_active && ev.key_match && pend_addr_r != idx_r) begin
              last_nxt = 1'b0;
            end
            if (ev.is_inactive) begin
              we.st_we = 1'b1;
              st_wdata = ev.expire ? sia_pkg::ST_FREE : ev.aged;
              if (ev.expire && exp_r != sia_pkg::EXP_MAX) begin
                exp_nxt = exp_r + 8'd1;
              end
            end
          end
        end
      end
      S_FIN: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
        kept_nxt  = 1'b0;
        reused_nxt = 1'b0;
        expired_nxt = 8'd0;
        if (kind_r == sia_pkg::KIND_ALLOC) begin
          if (fi_r || ff_r) begin
            we.st_we    = 1'b1;
            we.ow_we    = !fi_r;
            wr_addr     = g_slot;
            st_wdata    = sia_pkg::ST_ACTIVE;
            outcome_nxt = sia_pkg::OUT_OK;
            granted_nxt = g_wide[6:0];
            reused_nxt  = fi_r;
          end else begin
            outcome_nxt = sia_pkg::OUT_FULL;
            granted_nxt = 7'd0;
          end
        end else begin
          we.st_we    = 1'b1;
          wr_addr     = idx_r;
          st_wdata    = last_r ? sia_pkg::ST_INACT_START : sia_pkg::ST_FREE;
          outcome_nxt = sia_pkg::OUT_OK;
          granted_nxt = idx7_r;
          kept_nxt    = last_r;
          expired_nxt = exp_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
      pend_r  <= 1'b0;
      thr_r   <= sia_pkg::THR_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      pend_r  <= pend_nxt;
      thr_r   <= thr_nxt;
      ov_r    <= ov_nxt;
    end
    pend_addr_r <= pend_addr_nxt;
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    idx_r       <= idx_nxt;
    idx7_r      <= idx7_nxt;
    oor_r       <= oor_nxt;
    fi_r        <= fi_nxt;
    islot_r     <= islot_nxt;
    ff_r        <= ff_nxt;
    fslot_r     <= fslot_nxt;
    last_r      <= last_nxt;
    exp_r       <= exp_nxt;
    outcome_r   <= outcome_nxt;
    granted_r   <= granted_nxt;
    reused_r    <= reused_nxt;
    kept_r      <= kept_nxt;
    expired_r   <= expired_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign rd_addr           = addr_r[IDX_W-1:0];
  assign key               = key_r;
  assign thr               = thr_r;
  assign out_valid         = ov_r;
  assign out_outcome       = outcome_r;
  assign out_granted_slot  = granted_r;
  assign out_reused        = reused_r;
  assign out_kept_inactive = kept_r;
  assign out_expired_count = expired_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the block busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r)
    else $error("result strobe held for more than one cycle");

  a_scan_write_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && we.st_we) |-> (pend_r && kind_r == sia_pkg::KIND_RELEASE))
    else $error("status write during scan without a pending read");

  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && outcome_r == sia_pkg::OUT_FULL) |-> (granted_r == 7'd0 && expired_r == 8'd0
      && !reused_r && !kept_r))
    else $error("full result carries nonzero fields");

  a_reuse_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && reused_r) |-> (outcome_r == sia_pkg::OUT_OK && !kept_r && expired_r == 8'd0))
    else $error("reuse flag on a result that is not a successful allocate");

endmodule

`default_nettype wire

[sv/instance_slot_allocator_with_aging.sv]
// Top level of the instance slot allocator with aging.
// Instantiates sia_table, sia_slot_unit and sia_seq; depends on sia_pkg.
//
// Channel   Ports                                   Handshake
// input     in_kind, in_owner_key, in_slot_index    start high and busy low
// result    out_outcome .. out_expired_count        out_valid high for one cycle
// config    cfg_wr_data                             cfg_wr_en high
//
// An allocate and a release of an active slot both scan the whole table, paced by the
// scan that reads one slot per cycle through the single table read port.
// A release of a slot that is not active skips the scan: S_REL_RD, S_REL_CHK, then idle.
// After reset a clearing pass frees every slot; busy stays high.
// The result beat comes from registers loaded in the last state of the work; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module instance_slot_allocator_with_aging #(
  parameter int NUM_SLOTS = sia_pkg::DEF_NUM_SLOTS,
  parameter int KEY_BITS  = sia_pkg::DEF_KEY_BITS
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_kind,
  input  wire  [31:0] in_owner_key,
  input  wire  [6:0]  in_slot_index,
  input  wire         cfg_wr_en,
  input  wire  [6:0]  cfg_wr_data,
  output logic        out_valid,
  output logic [1:0]  out_outcome,
  output logic [6:0]  out_granted_slot,
  output logic        out_reused,
  output logic        out_kept_inactive,
  output logic [7:0]  out_expired_count
);

  localparam int IDX_W = $clog2(NUM_SLOTS);

  logic [IDX_W-1:0]    rd_addr;
  logic [6:0]          rd_status;
  logic [KEY_BITS-1:0] rd_owner;
  sia_pkg::tbl_we_t    we;
  logic [IDX_W-1:0]    wr_addr;
  logic [6:0]          st_wdata;
  logic [KEY_BITS-1:0] ow_wdata;
  logic [KEY_BITS-1:0] key;
  logic [6:0]          thr;
  sia_pkg::slot_eval_t ev;

  sia_table #(
    .NUM_SLOTS (NUM_SLOTS),
    .KEY_BITS  (KEY_BITS)
  ) u_table (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .rd_status (rd_status),
    .rd_owner  (rd_owner),
    .we        (we),
    .wr_addr   (wr_addr),
    .st_wdata  (st_wdata),
    .ow_wdata  (ow_wdata)
  );

  sia_slot_unit #(
    .KEY_BITS (KEY_BITS)
  ) u_slot_unit (
    .status (rd_status),
    .owner  (rd_owner),
    .key    (key),
    .thr    (thr),
    .ev     (ev)
  );

  sia_seq #(
    .NUM_SLOTS (NUM_SLOTS),
    .KEY_BITS  (KEY_BITS)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_kind           (in_kind),
    .in_owner_key      (in_owner_key),
    .in_slot_index     (in_slot_index),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .rd_addr           (rd_addr),
    .rd_owner          (rd_owner),
    .ev                (ev),
    .key               (key),
    .thr               (thr),
    .we                (we),
    .wr_addr           (wr_addr),
    .st_wdata          (st_wdata),
    .ow_wdata          (ow_wdata),
    .out_valid         (out_valid),
    .out_outcome       (out_outcome),
    .out_granted_slot  (out_granted_slot),
    .out_reused        (out_reused),
    .out_kept_inactive (out_kept_inactive),
    .out_expired_count (out_expired_count)
  );

endmodule

`default_nettype wire
